// ===== src/lru_slot_tracker_top_macros.svh =====
// ----------------------------------------------------------------------------
// LRU slot tracker assertion macros
// Concurrent check shorthands shared by the tracker RTL.
// ----------------------------------------------------------------------------
`ifndef LRU_SLOT_TRACKER_TOP_MACROS_SVH
`define LRU_SLOT_TRACKER_TOP_MACROS_SVH

// check cons in the same cycle as ante
`define LST_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// check cons in the cycle after ante
`define LST_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/lst_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU slot tracker package
// Field widths, request codes and reset values for the tracker.
// ----------------------------------------------------------------------------
package lst_pkg;

   localparam int SLOTS_DEFAULT = 64;

   localparam int TYPE_W     = 2;
   localparam int SLOT_W     = 6;
   localparam int MODE_W     = 2;
   localparam int OCC_W      = 7;
   localparam int MAX_W      = 7;
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 16;
   localparam int RSP_USER_W = 1;

   localparam logic [MAX_W-1:0] MAX_ENTRIES_RESET = 7'd54;

   localparam logic [TYPE_W-1:0] OP_OPEN  = 2'd0;
   localparam logic [TYPE_W-1:0] OP_TOUCH = 2'd1;
   localparam logic [TYPE_W-1:0] OP_CLOSE = 2'd2;
   localparam logic [TYPE_W-1:0] OP_QUERY = 2'd3;

   localparam logic STATUS_DONE   = 1'b0;
   localparam logic STATUS_REJECT = 1'b1;

endpackage

// ===== src/lst_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU slot tracker store
// One write port, one registered read port; read data holds until next read.
// ----------------------------------------------------------------------------
module lst_ram #(
   parameter int DEPTH = lst_pkg::SLOTS_DEFAULT,
   parameter int WIDTH = lst_pkg::MODE_W
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] ram_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ram_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= ram_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/lru_slot_tracker_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU slot tracker
// Least-recently-used order over numbered slots, kept as a doubly linked list
// in prev/next link stores, with open, touch, close and query requests.
// ----------------------------------------------------------------------------
// channel  direction  word
// req      in         tuser: req_type; tdata: slot, access_mode
// rsp      out        tuser: status; tdata: evicted_valid, evicted_slot,
//                     mode_out, occupancy
// csr      in         max_entries, written when csr_wr_en is high
//
// One request at a time. Rejects, queries and touches of the tail go to done;
// opens without eviction pass through append, closes through unlink, and
// touches and evicting opens through unlink then append, as the next-link
// store has a single write port. A finished word waits in the output register;
// the next request is taken meanwhile and stalls only in done while that word
// is held. Synchronous reset empties the list at once; no clearing pass.
// ----------------------------------------------------------------------------
`include "lru_slot_tracker_top_macros.svh"

module lru_slot_tracker_top #(
   parameter int SLOTS = lst_pkg::SLOTS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [lst_pkg::REQ_DATA_W-1:0]  req_tdata,   // slot, access_mode
   input  logic [lst_pkg::TYPE_W-1:0]      req_tuser,   // req_type
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // evicted_valid, evicted_slot, mode_out, occupancy
   output logic [lst_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic [lst_pkg::RSP_USER_W-1:0]  rsp_tuser,   // status
   input  logic                            csr_wr_en,
   input  logic [lst_pkg::MAX_W-1:0]       csr_wr_data
);

   localparam int AW  = $clog2(SLOTS);
   localparam int LW  = AW + 1;
   localparam int SFW = lst_pkg::SLOT_W;
   localparam int MW  = lst_pkg::MODE_W;
   localparam int OCW = lst_pkg::OCC_W;
   localparam logic [LW-1:0]  NIL     = {LW{1'b1}};
   localparam logic [OCW-1:0] OCC_ONE = OCW'(1);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_UNLINK = 2'd1;
   localparam logic [1:0] ST_APPEND = 2'd2;
   localparam logic [1:0] ST_DONE   = 2'd3;

   // control state
   logic [1:0]                 state_ff, state_in;
   logic [LW-1:0]              head_ff, head_in;
   logic [LW-1:0]              tail_ff, tail_in;
   logic [OCW-1:0]             count_ff, count_in;
   logic [SLOTS-1:0]           present_ff, present_in;
   logic [lst_pkg::MAX_W-1:0]  max_ff;
   logic                       rsp_valid_ff, rsp_valid_in;

   // request held while at work
   logic [lst_pkg::TYPE_W-1:0] op_ff;
   logic [AW-1:0]              slot_ff;
   logic [MW-1:0]              mode_ff;
   logic [AW-1:0]              unl_ff;
   logic                       reject_ff, evict_ff, append_ff;

   // output word
   logic                       rsp_status_ff;
   logic                       rsp_ev_valid_ff;
   logic [SFW-1:0]             rsp_ev_slot_ff;
   logic [MW-1:0]              rsp_mode_ff;
   logic [OCW-1:0]             rsp_occ_ff;

   // accept-side decode
   logic [SFW-1:0]             in_slot;
   logic [MW-1:0]              in_mode;
   logic [AW-1:0]              in_addr;
   logic                       in_range, in_present, in_is_tail, head_ok;
   logic                       accept, dec_reject, dec_evict, dec_unlink, dec_append;
   logic                       rsp_load;

   // store ports
   logic                       next_we, prev_we, mode_we;
   logic [AW-1:0]              next_waddr, prev_waddr, links_raddr;
   logic [LW-1:0]              next_wdata, prev_wdata, next_rd, prev_rd;
   logic [MW-1:0]              mode_rd;
   logic                       p_ok, n_ok;
   logic [LW-1:0]              unl_head, unl_tail;

   assign in_slot    = req_tdata[SFW-1:0];
   assign in_mode    = req_tdata[SFW+MW-1:SFW];
   assign in_addr    = AW'(in_slot);
   assign in_range   = int'(in_slot) < SLOTS;
   assign in_present = in_range && present_ff[in_addr];
   assign in_is_tail = tail_ff == LW'(in_slot);
   assign head_ok    = head_ff != NIL;

   assign req_tready = state_ff == ST_IDLE;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      dec_reject = 1'b1;
      dec_evict  = 1'b0;
      dec_unlink = 1'b0;
      dec_append = 1'b0;
      unique case (req_tuser)
         lst_pkg::OP_OPEN: begin
            dec_reject = in_present || !in_range;
            dec_evict  = !dec_reject && (count_ff >= max_ff) && head_ok;
            dec_unlink = dec_evict;
            dec_append = !dec_reject;
         end
         lst_pkg::OP_TOUCH: begin
            dec_reject = !in_present;
            dec_unlink = in_present && !in_is_tail;
            dec_append = in_present && !in_is_tail;
         end
         lst_pkg::OP_CLOSE: begin
            dec_reject = !in_present;
            dec_unlink = in_present;
         end
         lst_pkg::OP_QUERY: begin
            dec_reject = !in_present;
         end
         default: begin
            dec_reject = 1'b1;
         end
      endcase
   end

   // an open unlinks the head, a touch or close the requested slot
   assign links_raddr = (req_tuser == lst_pkg::OP_OPEN) ? head_ff[AW-1:0] : in_addr;

   assign p_ok = prev_rd != NIL;
   assign n_ok = next_rd != NIL;

   always_comb begin
      unl_head = p_ok ? head_ff : next_rd;
      unl_tail = n_ok ? tail_ff : prev_rd;
      if (unl_head == NIL || unl_tail == NIL) begin
         unl_head = NIL;
         unl_tail = NIL;
      end
   end

   assign rsp_load = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      present_in   = present_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      next_we      = 1'b0;
      next_waddr   = slot_ff;
      next_wdata   = NIL;
      prev_we      = 1'b0;
      prev_waddr   = slot_ff;
      prev_wdata   = tail_ff;
      mode_we      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (dec_unlink) begin
                  state_in = ST_UNLINK;
               end else if (dec_append) begin
                  state_in = ST_APPEND;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_UNLINK: begin
            next_we    = p_ok;
            next_waddr = prev_rd[AW-1:0];
            next_wdata = next_rd;
            prev_we    = n_ok;
            prev_waddr = next_rd[AW-1:0];
            prev_wdata = prev_rd;
            head_in    = unl_head;
            tail_in    = unl_tail;
            present_in[unl_ff] = 1'b0;
            count_in   = count_ff - OCC_ONE;
            state_in   = append_ff ? ST_APPEND : ST_DONE;
         end
         ST_APPEND: begin
            prev_we    = 1'b1;
            prev_waddr = slot_ff;
            prev_wdata = tail_ff;
            next_we    = tail_ff != NIL;
            next_waddr = tail_ff[AW-1:0];
            next_wdata = LW'(slot_ff);
            mode_we    = op_ff == lst_pkg::OP_OPEN;
            if (!head_ok) begin
               head_in = LW'(slot_ff);
            end
            tail_in    = LW'(slot_ff);
            present_in[slot_ff] = 1'b1;
            count_in   = count_ff + OCC_ONE;
            state_in   = ST_DONE;
         end
         ST_DONE: begin
            // terminate the appended slot; repeats harmlessly while stalled
            next_we    = append_ff;
            next_waddr = slot_ff;
            next_wdata = NIL;
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= NIL;
         tail_ff      <= NIL;
         count_ff     <= '0;
         present_ff   <= '0;
         max_ff       <= lst_pkg::MAX_ENTRIES_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         present_ff   <= present_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            max_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff     <= req_tuser;
         slot_ff   <= in_addr;
         mode_ff   <= in_mode;
         unl_ff    <= links_raddr;
         reject_ff <= dec_reject;
         evict_ff  <= dec_evict;
         append_ff <= dec_append;
      end
      if (rsp_load) begin
         rsp_status_ff   <= reject_ff ? lst_pkg::STATUS_REJECT : lst_pkg::STATUS_DONE;
         rsp_ev_valid_ff <= evict_ff;
         rsp_ev_slot_ff  <= evict_ff ? SFW'(unl_ff) : '0;
         rsp_mode_ff     <= (op_ff == lst_pkg::OP_QUERY && !reject_ff) ? mode_rd : '0;
         rsp_occ_ff      <= count_ff;
      end
   end

   lst_ram #(
      .DEPTH (SLOTS),
      .WIDTH (LW)
   ) u_next_ram (
      .clock   (clock),
      .wr_en   (next_we),
      .wr_addr (next_waddr),
      .wr_data (next_wdata),
      .rd_en   (accept),
      .rd_addr (links_raddr),
      .rd_data (next_rd)
   );

   lst_ram #(
      .DEPTH (SLOTS),
      .WIDTH (LW)
   ) u_prev_ram (
      .clock   (clock),
      .wr_en   (prev_we),
      .wr_addr (prev_waddr),
      .wr_data (prev_wdata),
      .rd_en   (accept),
      .rd_addr (links_raddr),
      .rd_data (prev_rd)
   );

   lst_ram #(
      .DEPTH (SLOTS),
      .WIDTH (MW)
   ) u_mode_ram (
      .clock   (clock),
      .wr_en   (mode_we),
      .wr_addr (slot_ff),
      .wr_data (mode_ff),
      .rd_en   (accept),
      .rd_addr (in_addr),
      .rd_data (mode_rd)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_occ_ff, rsp_mode_ff, rsp_ev_slot_ff, rsp_ev_valid_ff};
   assign rsp_tuser  = rsp_status_ff;

   `LST_ASSERT_NOW(a_head_tail_nil, clock, reset, 1'b1, (head_ff == NIL) == (tail_ff == NIL), "head and tail disagree on empty list")

   `LST_ASSERT_NOW(a_head_present, clock, reset, head_ff != NIL, present_ff[head_ff[AW-1:0]], "head slot not marked present")

   `LST_ASSERT_NOW(a_idle_no_write, clock, reset, state_ff == ST_IDLE, !next_we && !prev_we && !mode_we, "store written while idle")

   `LST_ASSERT_NEXT(a_accept_busy, clock, reset, accept, state_ff != ST_IDLE, "accepted request left no work")

   `LST_ASSERT_NEXT(a_rsp_from_done, clock, reset, state_ff != ST_DONE && !rsp_valid_ff, !rsp_valid_ff, "result word raised outside completion")

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU slot tracker testbench
// Drives open, touch, close and query requests through the request stream
// and checks every response word against an in-bench model of the LRU list.
// Directed cases come first, then random traffic at several occupancy limits.
// Both stream sides idle at random, except in the steady random run.
// ----------------------------------------------------------------------------
module testbench;

   localparam logic [6:0] NO_LINK = 7'h7f;

   typedef struct packed {
      logic       status;
      logic       ev_valid;
      logic [5:0] ev_slot;
      logic [1:0] mode;
      logic [6:0] occ;
   } lru_result_type;

   logic                            clock       = 1'b0;
   logic                            reset       = 1'b1;
   logic                            req_tvalid  = 1'b0;
   logic                            req_tready;
   logic [lst_pkg::REQ_DATA_W-1:0]  req_tdata   = '0;
   logic [lst_pkg::TYPE_W-1:0]      req_tuser   = '0;
   logic                            rsp_tvalid;
   logic                            rsp_tready  = 1'b0;
   logic [lst_pkg::RSP_DATA_W-1:0]  rsp_tdata;
   logic [lst_pkg::RSP_USER_W-1:0]  rsp_tuser;
   logic                            csr_wr_en   = 1'b0;
   logic [lst_pkg::MAX_W-1:0]       csr_wr_data = '0;

   // list model
   logic [6:0] link_prev [64];
   logic [6:0] link_next [64];
   logic [1:0] mode_store [64];
   logic       in_list [64];
   logic [6:0] lru_head;
   logic [6:0] mru_tail;
   logic [6:0] entry_total;
   logic [6:0] occ_limit;

   lru_result_type expected_results[$];
   bit steady = 1'b0;
   int errors = 0;
   int words_checked = 0;
   int requests_sent = 0;
   int rejects_seen = 0;
   int evictions_seen = 0;
   int peak_occupancy = 0;

   lru_slot_tracker_top uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always #5 clock = ~clock;

   initial begin
      #5_000_000;
      $display("timeout after %0d requests, %0d words", requests_sent, words_checked);
      $display("status: fail");
      $finish;
   end

   function automatic bit linked(input logic [6:0] l);
      return l < 7'd64;
   endfunction

   function automatic void link_at_tail(input logic [5:0] s);
      link_prev[s] = mru_tail;
      link_next[s] = NO_LINK;
      if (linked(mru_tail)) link_next[mru_tail[5:0]] = {1'b0, s};
      if (!linked(lru_head)) lru_head = {1'b0, s};
      mru_tail = {1'b0, s};
      in_list[s] = 1'b1;
      entry_total = entry_total + 7'd1;
   endfunction

   function automatic void unlink_slot(input logic [5:0] s);
      logic [6:0] p;
      logic [6:0] n;
      p = link_prev[s];
      n = link_next[s];
      if (linked(p)) link_next[p[5:0]] = n;
      else lru_head = n;
      if (linked(n)) link_prev[n[5:0]] = p;
      else mru_tail = p;
      if (!linked(lru_head) || !linked(mru_tail)) begin
         lru_head = NO_LINK;
         mru_tail = NO_LINK;
      end
      in_list[s] = 1'b0;
      entry_total = entry_total - 7'd1;
   endfunction

   function automatic lru_result_type predict_request(input logic [1:0] kind,
                                                      input logic [5:0] s,
                                                      input logic [1:0] m);
      lru_result_type r;
      r = '0;
      if (kind == lst_pkg::OP_OPEN) begin
         if (in_list[s]) begin
            r.status = lst_pkg::STATUS_REJECT;
         end else begin
            if (entry_total >= occ_limit && linked(lru_head)) begin
               r.ev_valid = 1'b1;
               r.ev_slot  = lru_head[5:0];
               unlink_slot(lru_head[5:0]);
            end
            mode_store[s] = m;
            link_at_tail(s);
         end
      end else if (!in_list[s]) begin
         r.status = lst_pkg::STATUS_REJECT;
      end else if (kind == lst_pkg::OP_TOUCH) begin
         if (mru_tail != {1'b0, s}) begin
            unlink_slot(s);
            link_at_tail(s);
         end
      end else if (kind == lst_pkg::OP_CLOSE) begin
         unlink_slot(s);
      end else begin
         r.mode = mode_store[s];
      end
      r.occ = entry_total;
      if (r.status == lst_pkg::STATUS_REJECT) rejects_seen++;
      if (r.ev_valid) evictions_seen++;
      if (int'(entry_total) > peak_occupancy) peak_occupancy = int'(entry_total);
      return r;
   endfunction

   function automatic bit take_gap();
      return !steady && ($urandom_range(99) < 26);
   endfunction

   task automatic report_mismatch(input string field, input int got, input int want);
      $display("mismatch on word %0d: %s = %0d, expected %0d", words_checked, field, got, want);
      errors++;
   endtask

   task automatic send_request(input logic [1:0] kind, input logic [5:0] s,
                               input logic [1:0] m);
      while (take_gap()) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {m, s};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_results.push_back(predict_request(kind, s, m));
      requests_sent++;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_limit(input logic [6:0] value);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      occ_limit = value;
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic [5:0] pick_present();
      logic [5:0] s;
      int k;
      s = 6'($urandom_range(63));
      if (entry_total == 0) return s;
      k = $urandom_range(int'(entry_total) - 1);
      for (int i = 0; i < 64; i++) begin
         if (in_list[i]) begin
            if (k == 0) return 6'(i);
            k--;
         end
      end
      return s;
   endfunction

   function automatic logic [5:0] pick_absent();
      logic [5:0] s;
      s = 6'($urandom_range(63));
      for (int i = 0; i < 8 && in_list[s]; i++) s = 6'($urandom_range(63));
      return s;
   endfunction

   // hold rsp_tready low in about a quarter of cycles unless steady
   always @(posedge clock) begin
      rsp_tready <= steady || ($urandom_range(99) >= 26);
   end

   always @(posedge clock) begin
      lru_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_results.size() == 0) begin
            report_mismatch("unexpected word tdata", int'(rsp_tdata), 0);
         end else begin
            want = expected_results.pop_front();
            if (rsp_tuser[0] !== want.status)
               report_mismatch("status", rsp_tuser[0], want.status);
            if (rsp_tdata[0] !== want.ev_valid)
               report_mismatch("evicted_valid", rsp_tdata[0], want.ev_valid);
            if (rsp_tdata[6:1] !== want.ev_slot)
               report_mismatch("evicted_slot", rsp_tdata[6:1], want.ev_slot);
            if (rsp_tdata[8:7] !== want.mode)
               report_mismatch("mode_out", rsp_tdata[8:7], want.mode);
            if (rsp_tdata[15:9] !== want.occ)
               report_mismatch("occupancy", rsp_tdata[15:9], want.occ);
         end
         words_checked++;
      end
   end

   task automatic test_basic_ops();
      send_request(lst_pkg::OP_QUERY, 6'd7, 2'd0);
      send_request(lst_pkg::OP_TOUCH, 6'd7, 2'd3);
      send_request(lst_pkg::OP_CLOSE, 6'd7, 2'd0);
      send_request(lst_pkg::OP_OPEN,  6'd0, 2'd0);
      send_request(lst_pkg::OP_OPEN,  6'd63, 2'd3);
      send_request(lst_pkg::OP_OPEN,  6'd21, 2'd1);
      send_request(lst_pkg::OP_OPEN,  6'd42, 2'd2);
      send_request(lst_pkg::OP_OPEN,  6'd0, 2'd2);
      send_request(lst_pkg::OP_QUERY, 6'd63, 2'd0);
      send_request(lst_pkg::OP_QUERY, 6'd21, 2'd0);
      send_request(lst_pkg::OP_TOUCH, 6'd42, 2'd0);
      send_request(lst_pkg::OP_TOUCH, 6'd0, 2'd0);
      send_request(lst_pkg::OP_CLOSE, 6'd21, 2'd0);
      send_request(lst_pkg::OP_QUERY, 6'd21, 2'd0);
      send_request(lst_pkg::OP_CLOSE, 6'd63, 2'd0);
      send_request(lst_pkg::OP_CLOSE, 6'd0, 2'd0);
   endtask

   task automatic test_limit_extremes();
      set_limit(7'd1);
      send_request(lst_pkg::OP_OPEN, 6'd5, 2'd1);
      send_request(lst_pkg::OP_OPEN, 6'd6, 2'd3);
      set_limit(7'd0);
      send_request(lst_pkg::OP_CLOSE, 6'd6, 2'd0);
      send_request(lst_pkg::OP_OPEN, 6'd9, 2'd2);
      send_request(lst_pkg::OP_OPEN, 6'd10, 2'd0);
      send_request(lst_pkg::OP_CLOSE, 6'd10, 2'd0);
      send_request(lst_pkg::OP_CLOSE, 6'd10, 2'd0);
   endtask

   task automatic test_random_traffic(input int count, input logic [6:0] limit_value,
                                      input int open_pct, input bit no_gaps);
      logic [1:0] kind;
      logic [5:0] s;
      int r;
      set_limit(limit_value);
      steady = no_gaps;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(99);
         if (r < 8) begin
            kind = 2'($urandom_range(3));
            s    = 6'($urandom_range(63));
         end else if ($urandom_range(99) < open_pct) begin
            kind = lst_pkg::OP_OPEN;
            s    = pick_absent();
         end else begin
            r    = $urandom_range(2);
            kind = (r == 0) ? lst_pkg::OP_TOUCH :
                   (r == 1) ? lst_pkg::OP_CLOSE : lst_pkg::OP_QUERY;
            s    = pick_present();
         end
         send_request(kind, s, 2'($urandom_range(3)));
      end
      steady = 1'b0;
   endtask

   initial begin
      for (int i = 0; i < 64; i++) in_list[i] = 1'b0;
      lru_head    = NO_LINK;
      mru_tail    = NO_LINK;
      entry_total = '0;
      occ_limit   = lst_pkg::MAX_ENTRIES_RESET;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_basic_ops();
      test_limit_extremes();
      test_random_traffic(240, 7'd54, 55, 1'b0);
      test_random_traffic(240, 7'd64, 62, 1'b0);
      test_random_traffic(240, 7'd127, 58, 1'b1);
      test_random_traffic(240, 7'd1, 45, 1'b0);
      test_random_traffic(240, 7'd0, 45, 1'b0);
      test_random_traffic(240, 7'($urandom_range(2, 63)), 55, 1'b0);
      drain();
      repeat (20) @(posedge clock);

      $display("covered %0d requests and %0d response words across eight limit settings",
               requests_sent, words_checked);
      $display("%0d rejects, %0d evictions, peak occupancy %0d",
               rejects_seen, evictions_seen, peak_occupancy);
      if (errors == 0 && expected_results.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("%0d mismatches, %0d words outstanding", errors, expected_results.size());
         $display("status: fail");
      end
      $finish;
   end

endmodule
